// File: hdl/wtsp_pkg.sv
`default_nettype none
package wtsp_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int FRAC_BITS_DEF = 16;

  // Quotient bits below the clamp point of a normalized value (limit is 2^47).
  localparam int NDC_QBITS = 47;

  // Input item kinds carried on tuser.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_POINT = 1'b1;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DMIN   = 2'd2;
  localparam logic [1:0] REG_DMAX   = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [13:0] WIDTH_RST  = 14'd1920;
  localparam logic [13:0] HEIGHT_RST = 14'd1080;
  localparam logic [31:0] DMIN_RST   = 32'd65536;
  localparam logic [31:0] DMAX_RST   = 32'd75366;

  // Matrix storage, entry row*4+col.
  typedef logic [15:0][31:0] mat_t;

  // One lane of the restoring divider.
  typedef struct packed {
    logic [63:0]           r;
    logic [NDC_QBITS-1:0]  q;
    logic [NDC_QBITS-1:0]  nlo;
    logic                  big;
    logic                  neg;
  } div_lane_t;

  // Payload of one divider stage: three lanes share the divisor.
  typedef struct packed {
    logic             wzero;
    logic [63:0]      ud;
    div_lane_t [2:0]  lane;
  } div_pipe_t;

  // Signed 64-bit add that saturates at both ends.
  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    logic               ovf;
    begin
      s   = a + b;
      ovf = (a[63] == b[63]) && (s[63] != a[63]);
      if (ovf) begin
        sat_add = a[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else begin
        sat_add = s;
      end
    end
  endfunction

endpackage
`default_nettype wire

// File: hdl/wtsp_transform.sv
`default_nettype none
module wtsp_transform #(
  parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   in_vld,
  input  wire logic [2:0][39:0]       in_pos,
  input  wire wtsp_pkg::mat_t         mat,
  output logic                        out_vld,
  output logic signed [63:0]          out_clip [4]
);

  localparam int XH_W = 40 - FRAC_BITS;
  localparam int PH_W = XH_W + 32;
  localparam int PL_W = FRAC_BITS + 33;

  logic                    v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic [2:0][39:0]        pos_r;
  logic signed [PH_W-1:0]  ph_r   [3][4];
  logic signed [PH_W-1:0]  ph_nxt [3][4];
  logic signed [PL_W-1:0]  pl_r   [3][4];
  logic signed [PL_W-1:0]  pl_nxt [3][4];
  logic signed [31:0]      bias_r [4];
  logic signed [63:0]      bias2_r [4];
  logic signed [63:0]      bias3_r [4];
  logic signed [63:0]      term_r  [3][4];
  logic signed [63:0]      term_nxt [3][4];
  logic signed [63:0]      acc4_r [4];
  logic signed [63:0]      acc5_r [4];
  logic signed [63:0]      acc6_r [4];
  logic signed [63:0]      t4_r   [2][4];
  logic signed [63:0]      t5_r   [4];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // Split each coordinate into a floored high part and an unsigned low part.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        ph_nxt[r][c] = $signed(pos_r[r][39:FRAC_BITS]) * $signed(mat[r*4+c]);
        pl_nxt[r][c] = $signed({1'b0, pos_r[r][FRAC_BITS-1:0]}) * $signed(mat[r*4+c]);
      end
    end
  end

  // The low product is floored back to the fixed-point grid.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) begin
        term_nxt[r][c] = 64'(ph_r[r][c]) + 64'(pl_r[r][c] >>> FRAC_BITS);
      end
    end
  end

  // Stage payloads: products, terms, then three saturating adds.
  always_ff @(posedge clk) begin
    if (en) begin
      pos_r <= in_pos;
      for (int c = 0; c < 4; c++) begin
        bias_r[c]  <= $signed(mat[12+c]);
        bias2_r[c] <= 64'(bias_r[c]);
        bias3_r[c] <= bias2_r[c];
        acc4_r[c]  <= wtsp_pkg::sat_add(bias3_r[c], term_r[0][c]);
        t4_r[0][c] <= term_r[1][c];
        t4_r[1][c] <= term_r[2][c];
        acc5_r[c]  <= wtsp_pkg::sat_add(acc4_r[c], t4_r[0][c]);
        t5_r[c]    <= t4_r[1][c];
        acc6_r[c]  <= wtsp_pkg::sat_add(acc5_r[c], t5_r[c]);
        for (int r = 0; r < 3; r++) begin
          ph_r[r][c]   <= ph_nxt[r][c];
          pl_r[r][c]   <= pl_nxt[r][c];
          term_r[r][c] <= term_nxt[r][c];
        end
      end
    end
  end

  assign out_vld  = v6_r;
  assign out_clip = acc6_r;

endmodule
`default_nettype wire

// File: hdl/wtsp_div_prep.sv
`default_nettype none
module wtsp_div_prep #(
  parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire logic                in_vld,
  input  wire logic signed [63:0]  in_clip [4],
  output logic                     out_vld,
  output wtsp_pkg::div_pipe_t      out_data
);

  localparam int NW = 64 + FRAC_BITS;
  localparam int QB = wtsp_pkg::NDC_QBITS;

  logic                v7_r, v8_r;
  logic [2:0][63:0]    un_r;
  logic [2:0]          neg_r;
  logic [63:0]         ud_r;
  logic                wz_r;
  wtsp_pkg::div_pipe_t data_r, data_nxt;
  logic [NW-1:0]       num;
  logic [NW-QB-1:0]    hi;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v7_r <= in_vld;
      v8_r <= v7_r;
    end
  end

  // Magnitudes and quotient signs.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        un_r[i]  <= in_clip[i][63] ? 64'(-in_clip[i]) : 64'(in_clip[i]);
        neg_r[i] <= in_clip[i][63] ^ in_clip[3][63];
      end
      ud_r   <= in_clip[3][63] ? 64'(-in_clip[3]) : 64'(in_clip[3]);
      wz_r   <= (in_clip[3] == 64'sd0);
      data_r <= data_nxt;
    end
  end

  // Leading quotient bits at or above the clamp point decide saturation;
  // below it the partial remainder starts from the high dividend bits.
  always_comb begin
    data_nxt.wzero = wz_r;
    data_nxt.ud    = ud_r;
    num = '0;
    hi  = '0;
    for (int i = 0; i < 3; i++) begin
      num = {un_r[i], {FRAC_BITS{1'b0}}};
      hi  = num[NW-1:QB];
      data_nxt.lane[i].r   = 64'(hi);
      data_nxt.lane[i].q   = '0;
      data_nxt.lane[i].nlo = num[QB-1:0];
      data_nxt.lane[i].big = (64'(hi) >= ud_r);
      data_nxt.lane[i].neg = neg_r[i];
    end
  end

  assign out_vld  = v8_r;
  assign out_data = data_r;

endmodule
`default_nettype wire

// File: hdl/wtsp_div_stage.sv
`default_nettype none
module wtsp_div_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire wtsp_pkg::div_pipe_t  in_data,
  output logic                      out_vld,
  output wtsp_pkg::div_pipe_t       out_data
);

  localparam int QB = wtsp_pkg::NDC_QBITS;

  logic                vld_r;
  wtsp_pkg::div_pipe_t data_r, data_nxt;
  logic [64:0]         rs;
  logic [64:0]         diff;
  logic                ge;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  // One restoring step per lane: shift in a dividend bit, compare, subtract.
  always_comb begin
    data_nxt = in_data;
    rs   = '0;
    diff = '0;
    ge   = 1'b0;
    for (int i = 0; i < 3; i++) begin
      rs   = {in_data.lane[i].r, in_data.lane[i].nlo[QB-1]};
      diff = rs - {1'b0, in_data.ud};
      ge   = (rs >= {1'b0, in_data.ud});
      data_nxt.lane[i].r   = ge ? diff[63:0] : rs[63:0];
      data_nxt.lane[i].q   = {in_data.lane[i].q[QB-2:0], ge};
      data_nxt.lane[i].nlo = {in_data.lane[i].nlo[QB-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule
`default_nettype wire

// File: hdl/wtsp_screen.sv
`default_nettype none
module wtsp_screen #(
  parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire wtsp_pkg::div_pipe_t  in_data,
  input  wire logic [13:0]          width,
  input  wire logic [13:0]          height,
  input  wire logic signed [31:0]   depth_min,
  input  wire logic signed [31:0]   depth_max,
  output logic                      out_vld,
  output logic [31:0]               out_sx,
  output logic [31:0]               out_sy,
  output logic                      out_vis
);

  localparam int QB = wtsp_pkg::NDC_QBITS;
  localparam logic signed [49:0] ONE = 50'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  logic                     vf_r, vm_r, vo_r;
  logic signed [QB+1:0]     nx_r, ny_r;
  logic signed [QB+1:0]     ndc [3];
  logic [QB:0]              mag;
  logic                     visf_r, vism_r, viso_r;
  logic                     vis_nxt;
  logic signed [63:0]       px_r, py_r;
  logic signed [63:0]       tx, ty;
  logic [31:0]              sx_r, sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
      vm_r <= 1'b0;
      vo_r <= 1'b0;
    end else if (en) begin
      vf_r <= in_vld;
      vm_r <= vf_r;
      vo_r <= vm_r;
    end
  end

  // Clamp and sign the quotients, then test depth against the open window.
  always_comb begin
    mag = '0;
    for (int i = 0; i < 3; i++) begin
      mag    = in_data.lane[i].big ? {1'b1, {QB{1'b0}}} : {1'b0, in_data.lane[i].q};
      ndc[i] = in_data.lane[i].neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
    vis_nxt = !in_data.wzero && (64'(ndc[2]) > 64'(depth_min))
              && (64'(ndc[2]) < 64'(depth_max));
  end

  // Floor of half the scaled value, saturated to 32 bits.
  always_comb begin
    tx = px_r >>> 1;
    ty = py_r >>> 1;
    if (tx > S32_MAX) tx = S32_MAX;
    if (tx < S32_MIN) tx = S32_MIN;
    if (ty > S32_MAX) ty = S32_MAX;
    if (ty < S32_MIN) ty = S32_MIN;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx_r   <= ndc[0];
      ny_r   <= ndc[1];
      visf_r <= vis_nxt;
      px_r   <= (50'(nx_r) + ONE) * $signed({1'b0, width});
      py_r   <= (ONE - 50'(ny_r)) * $signed({1'b0, height});
      vism_r <= visf_r;
      sx_r   <= vism_r ? tx[31:0] : 32'd0;
      sy_r   <= vism_r ? ty[31:0] : 32'd0;
      viso_r <= vism_r;
    end
  end

  assign out_vld = vo_r;
  assign out_sx  = sx_r;
  assign out_sy  = sy_r;
  assign out_vis = viso_r;

endmodule
`default_nettype wire

// File: hdl/world_to_screen_projection.sv
`default_nettype none
// Projects world points through a stored 4x4 matrix to window pixels in signed
// fixed point. Load beats (tuser low) write one matrix entry and give no result;
// point beats (tuser high) give one result each, in order. The pipeline takes a
// beat every cycle while the output is not stalled. A point passes in order
// through the matrix products and saturating sums, the divider setup, the
// quotient bit stages of the three parallel restoring dividers over 47 bits,
// and the depth test and pixel scaling.
// A stall on the output freezes the whole pipeline.
module world_to_screen_projection #(
  parameter int FRAC_BITS = wtsp_pkg::FRAC_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // entry_index, entry_value, pos_x, pos_y, pos_z, zero padding
  input  wire logic [159:0]  in_tdata,
  // opcode
  input  wire logic          in_tuser,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // screen_x, screen_y
  output logic [63:0]        out_tdata,
  // visible
  output logic               out_tuser,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_wdata
);

  localparam int DIV_STAGES = wtsp_pkg::NDC_QBITS;

  logic                 en;
  logic                 in_acc;
  logic [13:0]          width_r, height_r;
  logic signed [31:0]   dmin_r, dmax_r;
  wtsp_pkg::mat_t       mat_r;
  logic [2:0][39:0]     pos;
  logic                 clip_vld;
  logic signed [63:0]   clip [4];
  logic                 dv [DIV_STAGES+1];
  wtsp_pkg::div_pipe_t  dd [DIV_STAGES+1];
  logic [31:0]          sx, sy;

  // The pipeline advances whenever the output register is free or drained.
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= wtsp_pkg::WIDTH_RST;
      height_r <= wtsp_pkg::HEIGHT_RST;
      dmin_r   <= wtsp_pkg::DMIN_RST;
      dmax_r   <= wtsp_pkg::DMAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wtsp_pkg::REG_WIDTH:  width_r  <= cfg_wdata[13:0];
        wtsp_pkg::REG_HEIGHT: height_r <= cfg_wdata[13:0];
        wtsp_pkg::REG_DMIN:   dmin_r   <= cfg_wdata;
        wtsp_pkg::REG_DMAX:   dmax_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Matrix entries are written as load beats are accepted.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r <= '0;
    end else if (in_acc && (in_tuser == wtsp_pkg::OP_LOAD)) begin
      mat_r[in_tdata[3:0]] <= in_tdata[35:4];
    end
  end

  assign pos[0] = in_tdata[75:36];
  assign pos[1] = in_tdata[115:76];
  assign pos[2] = in_tdata[155:116];

  wtsp_transform #(.FRAC_BITS(FRAC_BITS)) u_transform (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_acc && (in_tuser == wtsp_pkg::OP_POINT)),
    .in_pos   (pos),
    .mat      (mat_r),
    .out_vld  (clip_vld),
    .out_clip (clip)
  );

  wtsp_div_prep #(.FRAC_BITS(FRAC_BITS)) u_div_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (clip_vld),
    .in_clip  (clip),
    .out_vld  (dv[0]),
    .out_data (dd[0])
  );

  // One stage per quotient bit.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    wtsp_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (dv[g]),
      .in_data  (dd[g]),
      .out_vld  (dv[g+1]),
      .out_data (dd[g+1])
    );
  end

  wtsp_screen #(.FRAC_BITS(FRAC_BITS)) u_screen (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (dv[DIV_STAGES]),
    .in_data   (dd[DIV_STAGES]),
    .width     (width_r),
    .height    (height_r),
    .depth_min (dmin_r),
    .depth_max (dmax_r),
    .out_vld   (out_tvalid),
    .out_sx    (sx),
    .out_sy    (sy),
    .out_vis   (out_tuser)
  );

  assign out_tdata = {sy, sx};

endmodule
`default_nettype wire
